@@ hw/rtl/deq_pkg.sv @@
package deq_pkg;

  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_POP_BACK   = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_PEEK_BACK  = 3'd4;
  localparam logic [2:0] MODE_PEEK_FRONT = 3'd5;
  localparam logic [2:0] MODE_CLEAR      = 3'd6;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  error;
    logic [5:0]  count;
  } deq_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_sel;
    logic     rd_sel;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue held in a row of CAPACITY cells, front element always in cell 0.
// Push front and pop front shift the whole row by one cell; push back loads the cell at the
// current count; back reads select the cell at count minus one. Every operation completes in
// the cycle its beat is accepted, and its result sits in an output register from the next cycle,
// so the block takes one beat per cycle whenever the result side keeps up (in_ready is low only
// while a result waits untaken). Pop or peek on an empty queue returns the empty error, push on a
// full queue returns the full error and drops the element; neither changes the contents. Elements
// are stored at ELEMENT_WIDTH bits. Cells are not cleared at reset; only occupied cells are read.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int CAPACITY      = 32,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            occ_r;
  logic [CW-1:0]            occ_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  deq_out_t                 out_data_r;
  deq_out_t                 out_data_nxt;
  logic                     in_fire;
  logic                     full;
  logic                     empty;
  cell_op_t                 op;
  logic [1:0]               err;
  logic                     rd_en;
  logic                     rd_back;
  logic [CW-1:0]            rd_idx;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [ELEMENT_WIDTH-1:0] rd_value;
  logic [ELEMENT_WIDTH-1:0] cell_q  [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_rd [CAPACITY];
  cell_ctrl_t               cell_ctrl [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (occ_r == CW'(CAPACITY));
  assign empty    = (occ_r == '0);
  assign elem     = ELEMENT_WIDTH'(in_data.value);

  always_comb begin
    op      = CELL_HOLD;
    occ_nxt = occ_r;
    err     = ERR_OK;
    rd_en   = 1'b0;
    rd_back = 1'b0;
    case (in_data.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          op      = (in_data.mode == MODE_PUSH_BACK) ? CELL_LOAD : CELL_SHR;
          occ_nxt = occ_r + CW'(1);
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        rd_back = 1'b1;
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (in_data.mode == MODE_POP_BACK) begin
            occ_nxt = occ_r - CW'(1);
          end
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (in_data.mode == MODE_POP_FRONT) begin
            op      = CELL_SHL;
            occ_nxt = occ_r - CW'(1);
          end
        end
      end
      MODE_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      op      = CELL_HOLD;
      occ_nxt = occ_r;
    end
  end

  assign rd_idx = rd_back ? (occ_r - CW'(1)) : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i] = '{op: op, wr_sel: (occ_r == CW'(i)), rd_sel: (rd_idx == CW'(i))};

    deq_cell #(
      .WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .new_data   (elem),
      .left_data  ((i == 0) ? elem : cell_q[(i == 0) ? 0 : i - 1]),
      .right_data (cell_q[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_q[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
  end

  always_comb begin
    out_data_nxt.value_out = rd_en ? 32'(rd_value) : 32'd0;
    out_data_nxt.error     = err;
    out_data_nxt.count     = 6'(occ_nxt);
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (in_data.mode == MODE_PUSH_BACK || in_data.mode == MODE_PUSH_FRONT))
    |=> (occ_r == $past(occ_r)))
    else $error("dropped push changed occupancy");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == MODE_CLEAR) |=> (occ_r == '0))
    else $error("clear left elements");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error != ERR_OK) |-> (out_data_r.value_out == 32'd0))
    else $error("error beat carries data");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_data_r.count == 6'(occ_r)))
    else $error("reported count differs from occupancy");
`endif

endmodule

@@ hw/rtl/deq_cell.sv @@
module deq_cell import deq_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [WIDTH-1:0] new_data,
  input  logic [WIDTH-1:0] left_data,
  input  logic [WIDTH-1:0] right_data,
  output logic [WIDTH-1:0] data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;

  always_comb begin
    case (ctrl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_SHR:  data_nxt = left_data;
      CELL_SHL:  data_nxt = right_data;
      CELL_LOAD: data_nxt = ctrl.wr_sel ? new_data : data_r;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = ctrl.rd_sel ? data_r : '0;

endmodule
